[design/esc_pkg.sv]
// shared types, constants and calendar helpers for the epoch-to-calendar unit
package esc_pkg;

  localparam int EPOCH_W = 32;
  localparam int ZONE_W  = 12;
  localparam int DAYS_W  = 16;

  localparam logic [EPOCH_W-1:0] SECS_PER_DAY  = 32'd86400;
  localparam logic [EPOCH_W-1:0] SECS_PER_HOUR = 32'd3600;
  localparam logic [EPOCH_W-1:0] SECS_PER_MIN  = 32'd60;
  localparam logic [EPOCH_W-1:0] DAYS_PER_WEEK = 32'd7;
  localparam logic [EPOCH_W-1:0] FIRST_WEEKDAY = 32'd4;

  // year offset from 1900 of the first calendar year (1970)
  localparam logic [7:0] FIRST_YEAR_OFS = 8'd70;
  localparam logic [7:0] Y2000_OFS      = 8'd100;
  localparam logic [7:0] Y2100_OFS      = 8'd200;
  localparam logic [7:0] Y1900_OFS      = 8'd0;

  localparam logic [8:0] COMMON_YEAR_DAYS = 9'd365;
  localparam logic [3:0] LAST_MONTH       = 4'd11;
  localparam logic [3:0] FEB_INDEX        = 4'd1;

  localparam logic [4:0] MONTH_DAYS [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  typedef logic signed [ZONE_W-1:0] zone_t;

  typedef struct packed {
    logic [EPOCH_W-1:0] epoch_seconds;
    logic               want_local;
  } in_t;

  typedef struct packed {
    logic [5:0] second_of_minute;
    logic [5:0] minute_of_hour;
    logic [4:0] hour_of_day;
    logic [2:0] week_day;
    logic [7:0] year_since_1900;
    logic [8:0] day_of_year;
    logic [3:0] month_index;
    logic [4:0] day_of_month;
    logic       is_utc;
  } out_t;

  typedef struct packed {
    logic idle;
    logic done;
  } seq_stat_t;

  // gregorian leap rule for years 1900..2155 given as offset from 1900
  function automatic logic leap_year(input logic [7:0] y);
    return (y[1:0] == 2'b00) && (y != Y1900_OFS) && (y != Y2100_OFS);
  endfunction

  function automatic logic [8:0] year_len(input logic [7:0] y);
    return COMMON_YEAR_DAYS + {8'd0, leap_year(y)};
  endfunction

  function automatic logic [4:0] month_len(input logic lp, input logic [3:0] m);
    return MONTH_DAYS[m] + {4'd0, (lp && (m == FEB_INDEX))};
  endfunction

endpackage

[design/esc_chan_if.sv]
// valid/ready channel carrying one payload beat
interface esc_chan_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[design/epoch_seconds_to_calendar_unit.sv]
// top level of the epoch-seconds to calendar-date converter
//
//   channel   dir   payload                               beat when
//   cfg       in    zone_minutes_east (12b signed)        cfg.valid & cfg.ready
//   stamp     in    epoch_seconds, want_local             stamp.valid & stamp.ready
//   cal       out   broken-down date and time, is_utc     cal.valid & cal.ready
//
// a stamp runs from accept to result through 16 day-division steps, 5 hour,
// 6 minute and 13 weekday steps, one step per whole year past 1970 plus a
// closing one, one per whole month plus a closing one, and a hand-off state,
// all on one shared 32-bit subtract/compare unit; the next stamp goes in once the sequencer is idle again
// stamp is not ready while a conversion runs; a finished result moves into
// the output register, so a new stamp is taken while cal still stalls
// rst is synchronous and clears the sequencer, output valid and zone to 0
// cfg is always ready and should only be written while the unit is idle
module epoch_seconds_to_calendar_unit
  import esc_pkg::*;
(
  input logic        clk,
  input logic        rst,
  esc_chan_if.sink   cfg,
  esc_chan_if.sink   stamp,
  esc_chan_if.source cal
);

  // zone offset register, written from the config channel
  zone_t zone;

  // sequencer handshake
  seq_stat_t stat;
  out_t      res;
  logic      start;
  logic      res_take;

  // output register
  logic out_valid;
  out_t out_data;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      zone <= '0;
    end else if (cfg.valid) begin
      zone <= cfg.data;
    end
  end

  // take a stamp only while the sequencer is idle
  assign stamp.ready = stat.idle && !rst;
  assign start       = stamp.valid && stamp.ready;

  esc_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .start_item (stamp.data),
    .zone       (zone),
    .res_take   (res_take),
    .stat       (stat),
    .res        (res)
  );

  // finished result moves over when the output register is free or draining
  assign res_take = stat.done && (!out_valid || cal.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (cal.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_data <= res;
    end
  end

  assign cal.valid = out_valid;
  assign cal.data  = out_data;

endmodule

[design/esc_sub_unit.sv]
// shared subtract and compare unit
module esc_sub_unit
  import esc_pkg::*;
(
  input  logic [EPOCH_W-1:0] a,
  input  logic [EPOCH_W-1:0] b,
  output logic [EPOCH_W-1:0] diff,
  output logic               ge
);

  logic [EPOCH_W:0] wide;

  assign wide = {1'b0, a} - {1'b0, b};
  assign diff = wide[EPOCH_W-1:0];
  assign ge   = ~wide[EPOCH_W];

endmodule

[design/esc_seq.sv]
// sequencer driving the shared subtract unit through division and peeling phases
module esc_seq
  import esc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  in_t       start_item,
  input  zone_t     zone,
  input  logic      res_take,
  output seq_stat_t stat,
  output out_t      res
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_DAY   = 3'd1;
  localparam logic [2:0] ST_HOUR  = 3'd2;
  localparam logic [2:0] ST_MIN   = 3'd3;
  localparam logic [2:0] ST_WDAY  = 3'd4;
  localparam logic [2:0] ST_YEAR  = 3'd5;
  localparam logic [2:0] ST_MONTH = 3'd6;
  localparam logic [2:0] ST_DONE  = 3'd7;

  logic [2:0]         state, state_next;
  logic [3:0]         cnt, cnt_next;
  logic [EPOCH_W-1:0] rem;
  logic [DAYS_W-1:0]  quot;
  logic [DAYS_W-1:0]  days;

  logic [EPOCH_W-1:0] sub_b, diff;
  logic               ge;
  logic [EPOCH_W-1:0] rem_step;
  logic [DAYS_W-1:0]  quot_step;
  logic [EPOCH_W-1:0] zone_ext, zone_secs, t_start;

  esc_sub_unit u_sub (
    .a    (rem),
    .b    (sub_b),
    .diff (diff),
    .ge   (ge)
  );

  // zone minutes times sixty, wrapping at 32 bits
  assign zone_ext  = {{(EPOCH_W-ZONE_W){zone[ZONE_W-1]}}, zone};
  assign zone_secs = (zone_ext << 6) - (zone_ext << 2);
  assign t_start   = start_item.epoch_seconds + (start_item.want_local ? zone_secs : '0);

  always_comb begin
    unique case (state)
      ST_DAY:   sub_b = SECS_PER_DAY << cnt;
      ST_HOUR:  sub_b = SECS_PER_HOUR << cnt;
      ST_MIN:   sub_b = SECS_PER_MIN << cnt;
      ST_WDAY:  sub_b = DAYS_PER_WEEK << cnt;
      ST_YEAR:  sub_b = {23'd0, year_len(res.year_since_1900)};
      ST_MONTH: sub_b = {27'd0, month_len(leap_year(res.year_since_1900), res.month_index)};
      default:  sub_b = '0;
    endcase
  end

  // one restoring division step
  assign rem_step  = ge ? diff : rem;
  assign quot_step = quot | (ge ? (DAYS_W'(1) << cnt) : '0);

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_DAY;
          cnt_next   = 4'd15;
        end
      end
      ST_DAY: begin
        cnt_next = cnt - 4'd1;
        if (cnt == 4'd0) begin
          state_next = ST_HOUR;
          cnt_next   = 4'd4;
        end
      end
      ST_HOUR: begin
        cnt_next = cnt - 4'd1;
        if (cnt == 4'd0) begin
          state_next = ST_MIN;
          cnt_next   = 4'd5;
        end
      end
      ST_MIN: begin
        cnt_next = cnt - 4'd1;
        if (cnt == 4'd0) begin
          state_next = ST_WDAY;
          cnt_next   = 4'd12;
        end
      end
      ST_WDAY: begin
        cnt_next = cnt - 4'd1;
        if (cnt == 4'd0) begin
          state_next = ST_YEAR;
        end
      end
      ST_YEAR: begin
        if (!ge) begin
          state_next = ST_MONTH;
        end
      end
      ST_MONTH: begin
        if (!ge || res.month_index == LAST_MONTH) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (res_take) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (start) begin
          rem        <= t_start;
          quot       <= '0;
          res.is_utc <= ~start_item.want_local;
        end
      end
      ST_DAY: begin
        rem <= rem_step;
        if (cnt == 4'd0) begin
          days <= quot_step;
          quot <= '0;
        end else begin
          quot <= quot_step;
        end
      end
      ST_HOUR: begin
        rem <= rem_step;
        if (cnt == 4'd0) begin
          res.hour_of_day <= quot_step[4:0];
          quot            <= '0;
        end else begin
          quot <= quot_step;
        end
      end
      ST_MIN: begin
        if (cnt == 4'd0) begin
          res.minute_of_hour   <= quot_step[5:0];
          res.second_of_minute <= rem_step[5:0];
          rem                  <= {16'd0, days} + FIRST_WEEKDAY;
          quot                 <= '0;
        end else begin
          rem  <= rem_step;
          quot <= quot_step;
        end
      end
      ST_WDAY: begin
        if (cnt == 4'd0) begin
          res.week_day        <= rem_step[2:0];
          rem                 <= {16'd0, days};
          res.year_since_1900 <= FIRST_YEAR_OFS;
        end else begin
          rem  <= rem_step;
          quot <= quot_step;
        end
      end
      ST_YEAR: begin
        if (ge) begin
          rem                 <= diff;
          res.year_since_1900 <= res.year_since_1900 + 8'd1;
        end else begin
          res.day_of_year <= rem[8:0];
          res.month_index <= '0;
        end
      end
      ST_MONTH: begin
        if (ge && res.month_index != LAST_MONTH) begin
          rem             <= diff;
          res.month_index <= res.month_index + 4'd1;
        end else begin
          res.day_of_month <= rem[4:0] + 5'd1;
        end
      end
      default: begin
      end
    endcase
  end

  assign stat.idle = (state == ST_IDLE);
  assign stat.done = (state == ST_DONE);

endmodule

[design/esc_chk.sv]
// port-level checker for the calendar converter and its bind
module esc_chk
  import esc_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input out_t out_data
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // a conversion keeps the unit busy for the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("stamp ready right after accept");

  // time-of-day and month fields stay in range
  a_clock_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.second_of_minute < 6'd60 && out_data.minute_of_hour < 6'd60
      && out_data.hour_of_day < 5'd24 && out_data.week_day < 3'd7
      && out_data.month_index < 4'd12 && out_data.day_of_month != 5'd0)
    else $error("clock or month field out of range");

  // year and day of year stay in range
  a_year_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.day_of_year < 9'd366 && out_data.year_since_1900 >= 8'd70
      && out_data.year_since_1900 <= 8'd206)
    else $error("year field out of range");

  // reset empties the output
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind epoch_seconds_to_calendar_unit esc_chk u_esc_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (stamp.valid),
  .in_ready  (stamp.ready),
  .out_valid (cal.valid),
  .out_ready (cal.ready),
  .out_data  (cal.data)
);
